// File: rtl/core/tile_texel_address_generator_assert.svh
// Assertion macros for the tile texel address generator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef TILE_TEXEL_ADDRESS_GENERATOR_ASSERT_SVH
`define TILE_TEXEL_ADDRESS_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TTAG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttag assertion failed");

// Implication after a fixed number of cycles.
`define TTAG_ASSERT_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("ttag delayed assertion failed");

`endif

// File: rtl/core/ttag_pkg.sv
// Shared types and constants for the tile texel address generator.
// No dependencies.
package ttag_pkg;

  localparam int ID_W        = 29;
  localparam int COLS_W      = 9;
  localparam int SPAN_W      = 13;
  localparam int OFF_W       = 12;
  localparam int TEX_W       = 5;   // log2 of tile size 32
  localparam int ROW_W       = 8;   // log2 of 256 tileset rows
  localparam int COORD_W     = 13;
  localparam int DIV_STEPS   = ID_W;
  localparam int STEPS_PER_STAGE = 4;
  localparam int NUM_STAGES  = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int STEP_W      = 6;
  localparam int LATENCY     = NUM_STAGES + 2;
  localparam logic [COLS_W-1:0] COLS_RESET = 9'd16;

  localparam int FLIP_H_BIT = 31;
  localparam int FLIP_V_BIT = 30;
  localparam int FLIP_D_BIT = 29;

  typedef struct packed {
    logic [31:0]        tile_word;
    logic [OFF_W-1:0]   col_offset;
    logic [OFF_W-1:0]   row_offset;
    logic [SPAN_W-1:0]  span_width;
    logic [SPAN_W-1:0]  span_height;
  } in_t;

  typedef struct packed {
    logic               drawn;
    logic               out_of_set;
    logic [COORD_W-1:0] source_x;
    logic [COORD_W-1:0] source_y;
  } out_t;

  // one texel axis: restoring divide of (32*num)/den, saturating
  typedef struct packed {
    logic [SPAN_W-1:0] den;
    logic [SPAN_W-1:0] rem;
    logic [TEX_W-1:0]  quo;
    logic              sat;
  } axis_t;

  typedef struct packed {
    logic              drawn;
    logic [ID_W-1:0]   dvd;   // id-1, consumed MSB first
    logic [COLS_W-1:0] cols;
    logic [COLS_W-1:0] rem;   // ends as tile column
    logic [ROW_W-1:0]  quo;   // low quotient bits: tile row
    logic              hi;    // any quotient bit above the row field
    axis_t             u;
    axis_t             v;
  } stage_t;

endpackage

// File: rtl/core/ttag_stage.sv
// One pipeline stage: a few steps of the tile id divide and texel divides.
// Depends on ttag_pkg.
module ttag_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [ttag_pkg::STEP_W-1:0] step_base,
  input  logic                      in_valid,
  input  ttag_pkg::stage_t          in_stage,
  output logic                      out_valid,
  output ttag_pkg::stage_t          out_stage
);
  import ttag_pkg::*;

  stage_t stage_nxt;
  stage_t stage_r;
  logic   valid_r;

  always_comb begin
    stage_t                s;
    logic [COLS_W:0]       r2;
    logic [SPAN_W:0]       t2;
    logic                  ge;
    logic [STEP_W-1:0]     k;
    s = in_stage;
    for (int j = 0; j < STEPS_PER_STAGE; j++) begin
      k = step_base + STEP_W'(j);
      if (k < STEP_W'(DIV_STEPS)) begin
        r2 = {s.rem, s.dvd[ID_W-1]};
        ge = r2 >= {1'b0, s.cols};
        s.rem = ge ? COLS_W'(r2 - {1'b0, s.cols}) : r2[COLS_W-1:0];
        s.hi  = s.hi | s.quo[ROW_W-1];
        s.quo = {s.quo[ROW_W-2:0], ge};
        s.dvd = {s.dvd[ID_W-2:0], 1'b0};
      end
      if (k < STEP_W'(TEX_W)) begin
        t2 = {s.u.rem, 1'b0};
        ge = t2 >= {1'b0, s.u.den};
        s.u.rem = ge ? SPAN_W'(t2 - {1'b0, s.u.den}) : t2[SPAN_W-1:0];
        s.u.quo = {s.u.quo[TEX_W-2:0], ge};
        t2 = {s.v.rem, 1'b0};
        ge = t2 >= {1'b0, s.v.den};
        s.v.rem = ge ? SPAN_W'(t2 - {1'b0, s.v.den}) : t2[SPAN_W-1:0];
        s.v.quo = {s.v.quo[TEX_W-2:0], ge};
      end
    end
    stage_nxt = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;

endmodule

// File: rtl/core/tile_texel_address_generator.sv
// Top level of the tile texel address generator.
// Depends on ttag_pkg, ttag_stage and tile_texel_address_generator_assert.svh.
//
// Takes one pixel beat per clock (busy never rises) and delivers its result
// as a one-cycle out_valid strobe after passing through one input register,
// eight divide stages of four restoring steps each (the 29-bit tile id divided
// by the column count sets the depth), and one output register.
// The receiver cannot stall. Write tileset_columns only while no beat is in
// flight; cfg_ready is always high.
module tile_texel_address_generator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  ttag_pkg::in_t               in_item,
  output logic                        out_valid,
  output ttag_pkg::out_t              out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ttag_pkg::COLS_W-1:0] cfg_data
);
  import ttag_pkg::*;

  logic [COLS_W-1:0] cols_r;
  logic              in_valid_r;
  stage_t            in_stage_r;
  stage_t            in_stage_nxt;
  logic              pipe_valid [NUM_STAGES+1];
  stage_t            pipe_stage [NUM_STAGES+1];
  logic              out_valid_r;
  out_t              out_item_r;
  out_t              out_item_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cols_r <= cfg_data;
    end
  end

  function automatic axis_t axis_init(logic [OFF_W-1:0] off, logic [SPAN_W-1:0] den,
                                      logic flip);
    axis_t            a;
    logic [SPAN_W-1:0] num;
    if (flip) begin
      num = ({1'b0, off} > den) ? '0 : SPAN_W'(den - {1'b0, off});
    end else begin
      num = {1'b0, off};
    end
    a.den = den;
    a.sat = num >= den;   // quotient would reach the tile size
    a.rem = num;
    a.quo = '0;
    return a;
  endfunction

  always_comb begin
    logic [ID_W-1:0]   id;
    logic              dflip;
    logic [OFF_W-1:0]  uo, vo;
    logic [SPAN_W-1:0] ud, vd;
    id    = in_item.tile_word[ID_W-1:0];
    dflip = in_item.tile_word[FLIP_D_BIT];
    uo = dflip ? in_item.row_offset  : in_item.col_offset;
    vo = dflip ? in_item.col_offset  : in_item.row_offset;
    ud = dflip ? in_item.span_height : in_item.span_width;
    vd = dflip ? in_item.span_width  : in_item.span_height;
    in_stage_nxt.drawn = (id != '0) && (in_item.span_width != '0)
                         && (in_item.span_height != '0);
    in_stage_nxt.dvd  = id - ID_W'(1);
    in_stage_nxt.cols = (cols_r == '0) ? COLS_W'(1) : cols_r;
    in_stage_nxt.rem  = '0;
    in_stage_nxt.quo  = '0;
    in_stage_nxt.hi   = 1'b0;
    in_stage_nxt.u = axis_init(uo, ud, in_item.tile_word[FLIP_H_BIT]);
    in_stage_nxt.v = axis_init(vo, vd, in_item.tile_word[FLIP_V_BIT]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_stage_r <= in_stage_nxt;
  end

  assign pipe_valid[0] = in_valid_r;
  assign pipe_stage[0] = in_stage_r;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    ttag_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .step_base (STEP_W'(g * STEPS_PER_STAGE)),
      .in_valid  (pipe_valid[g]),
      .in_stage  (pipe_stage[g]),
      .out_valid (pipe_valid[g+1]),
      .out_stage (pipe_stage[g+1])
    );
  end

  always_comb begin
    stage_t           s;
    logic [TEX_W-1:0] tx, ty;
    logic [COORD_W:0] sx;
    s  = pipe_stage[NUM_STAGES];
    tx = s.u.sat ? '1 : s.u.quo;
    ty = s.v.sat ? '1 : s.v.quo;
    sx = {s.rem, tx} ;
    out_item_nxt = '0;
    if (s.drawn) begin
      out_item_nxt.drawn      = 1'b1;
      out_item_nxt.out_of_set = s.hi;
      out_item_nxt.source_x   = sx[COORD_W-1:0];
      out_item_nxt.source_y   = s.hi ? '0 : {s.quo, ty};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pipe_valid[NUM_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`include "tile_texel_address_generator_assert.svh"

  `TTAG_ASSERT_IMP(a_undrawn_zero, out_valid && !out_item.drawn, (out_item.out_of_set == 1'b0) && (out_item.source_x == '0) && (out_item.source_y == '0))
  `TTAG_ASSERT_IMP(a_oos_row_zero, out_valid && out_item.out_of_set, out_item.drawn && (out_item.source_y == '0))
  `TTAG_ASSERT_DLY(a_latency, start && !busy, LATENCY, out_valid)
  `TTAG_ASSERT_IMP(a_never_busy, 1'b1, !busy)

endmodule
